// ----- hw/rtl/rtcc_pkg.sv -----
// shared types, constants and month tables for the rtc tick / calendar converter
// no dependencies
`timescale 1ns / 1ps

package rtcc_pkg;

   localparam int unsigned EPOCH_YEAR = 2009;
   localparam int NUM_STAGES = 7;

   localparam logic [31:0] SEC_PER_DAY = 32'd86400;
   localparam logic [16:0] SEC_PER_HOUR = 17'd3600;
   localparam logic [16:0] SEC_PER_MIN = 17'd60;
   localparam logic [31:0] DAYS_PER_YEAR = 32'd365;
   localparam logic [3:0] MONTH_FIRST = 4'd1;
   localparam logic [3:0] MONTH_LAST = 4'd12;

   // exact reciprocals: ceil(2^shift / divisor)
   localparam logic [31:0] RECIP_DAY = 32'd3257812231;
   localparam int DAY_SHIFT = 48;
   localparam int DAYS_W = 15;
   localparam logic [21:0] RECIP_QYEAR = 22'd3762874;
   localparam int QYEAR_SHIFT = 37;
   localparam int YOFF_W = 7;
   localparam logic [17:0] RECIP_HOUR = 18'd149131;
   localparam int HOUR_SHIFT = 29;
   localparam logic [12:0] RECIP_MIN = 13'd4370;
   localparam int MIN_SHIFT = 18;
   localparam logic [21:0] QYEAR_X100 = 22'd100;
   localparam logic [21:0] QYEAR_ROUND = 22'd99;

   typedef enum logic {
      OP_DECODE = 1'b0,
      OP_ENCODE = 1'b1
   } op_type;

   typedef struct packed {
      op_type      opcode;
      logic [31:0] tick_count;
      logic [11:0] cal_year;
      logic [3:0]  cal_month;
      logic [4:0]  cal_day;
      logic [4:0]  cal_hour;
      logic [5:0]  cal_minute;
      logic [5:0]  cal_second;
   } req_type;

   typedef struct packed {
      logic [11:0] out_year;
      logic [3:0]  out_month;
      logic [4:0]  out_day;
      logic [4:0]  out_hour;
      logic [5:0]  out_minute;
      logic [5:0]  out_second;
      logic [31:0] out_ticks;
      logic [4:0]  month_length;
      logic        date_ok;
   } rsp_type;

   typedef struct packed {
      logic [NUM_STAGES-1:0] en;
      logic [NUM_STAGES-1:0] vld;
   } pipe_ctl_type;

   // days before month index 0..11
   function automatic logic [8:0] days_before(input logic [3:0] midx, input logic leap);
      logic [8:0] d;
      unique case (midx)
         4'd0: d = 9'd0;
         4'd1: d = 9'd31;
         4'd2: d = 9'd59;
         4'd3: d = 9'd90;
         4'd4: d = 9'd120;
         4'd5: d = 9'd151;
         4'd6: d = 9'd181;
         4'd7: d = 9'd212;
         4'd8: d = 9'd243;
         4'd9: d = 9'd273;
         4'd10: d = 9'd304;
         4'd11: d = 9'd334;
         default: d = 9'd0;
      endcase
      if (leap && (midx >= 4'd2) && (midx <= 4'd11)) begin
         d = d + 9'd1;
      end
      return d;
   endfunction

   // days in month index 0..11, zero for anything else
   function automatic logic [4:0] month_days(input logic [3:0] midx, input logic leap);
      logic [4:0] d;
      unique case (midx)
         4'd0, 4'd2, 4'd4, 4'd6, 4'd7, 4'd9, 4'd11: d = 5'd31;
         4'd3, 4'd5, 4'd8, 4'd10: d = 5'd30;
         4'd1: d = leap ? 5'd29 : 5'd28;
         default: d = 5'd0;
      endcase
      return d;
   endfunction

endpackage

// ----- hw/rtl/rtcc_pipe_ctl.sv -----
// valid bits and per-stage load enables for the converter pipeline
// depends on rtcc_pkg
`timescale 1ns / 1ps

module rtcc_pipe_ctl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   input  logic                 out_stall,
   output rtcc_pkg::pipe_ctl_type ctl
);
   import rtcc_pkg::*;

   localparam int LAST = NUM_STAGES - 1;

   logic [NUM_STAGES-1:0] vld_ff;
   logic [NUM_STAGES-1:0] vld_in;
   logic [NUM_STAGES-1:0] en;

   // a stage loads when empty or when its beat moves on
   always_comb begin
      en[LAST] = !vld_ff[LAST] || !out_stall;
      for (int i = LAST - 1; i >= 0; i--) begin
         en[i] = !vld_ff[i] || en[i+1];
      end
   end

   always_comb begin
      vld_in[0] = en[0] ? in_valid : vld_ff[0];
      for (int i = 1; i < NUM_STAGES; i++) begin
         vld_in[i] = en[i] ? vld_ff[i-1] : vld_ff[i];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   assign ctl = '{en: en, vld: vld_ff};

`ifndef SYNTH
   a_out_hold: assert property (@(posedge clock) disable iff (reset)
      (vld_ff[LAST] && out_stall) |=> vld_ff[LAST])
      else $error("output beat dropped under stall");
   a_full_stall: assert property (@(posedge clock) disable iff (reset)
      !en[0] |-> (&vld_ff))
      else $error("input stalled with a bubble in the pipe");
   a_head_hold: assert property (@(posedge clock) disable iff (reset)
      (vld_ff[0] && !en[1]) |=> vld_ff[0])
      else $error("first stage lost a beat");
   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> (vld_ff == '0))
      else $error("pipe not empty after reset");
   a_count_move: assert property (@(posedge clock) disable iff (reset)
      (!in_valid && !out_stall && !vld_ff[LAST]) |=>
         ($countones(vld_ff) <= $countones($past(vld_ff))))
      else $error("beat created from nothing");
`endif

endmodule

// ----- hw/rtl/rtc_tick_calendar_converter.sv -----
// Converts between a count of half-second ticks since 1 January of the epoch year and
// calendar date and time, in both directions (opcode selects), using rtcc_pkg and
// rtcc_pipe_ctl. The block takes one beat per cycle while the input is not stalled and
// returns each result in order, after it has passed the seven register stages of reciprocal
// multiplies (day, quarter-year, hour, minute) and the subtractions that follow each.
// Stalls on the output back up stage by stage, so bubbles in the pipe are filled before
// the input is stalled. Every fourth year after the epoch is a leap year with no century
// rule; encoding wraps modulo 2^32.
`timescale 1ns / 1ps

module rtc_tick_calendar_converter (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  rtcc_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output rtcc_pkg::rsp_type rsp_data
);
   import rtcc_pkg::*;

   pipe_ctl_type ctl;

   rtcc_pipe_ctl u_ctl (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .out_stall (rsp_stall),
      .ctl       (ctl)
   );

   assign req_stall = !ctl.en[0];
   assign rsp_valid = ctl.vld[NUM_STAGES-1];

   // stage 1: day divide product, encode prep
   logic [30:0]       secs;
   logic [62:0]       day_prod;
   logic [11:0]       yoff_e;
   logic              leap_e;
   logic              mvalid_e;
   logic [3:0]        midx_e;

   op_type            s1_op_ff;
   logic [30:0]       s1_secs_ff;
   logic [DAYS_W-1:0] s1_days_ff;
   logic              s1_ok_ff;
   logic [11:0]       s1_yoff_ff;
   logic [4:0]        s1_mlen_ff;
   logic [8:0]        s1_lut_ff;
   logic [4:0]        s1_day_ff;
   logic [16:0]       s1_tod_ff;

   assign secs = req_data.tick_count[31:1];
   assign day_prod = 63'(secs) * 63'(RECIP_DAY);
   assign yoff_e = req_data.cal_year - 12'(EPOCH_YEAR);
   assign leap_e = (2'(yoff_e + 12'd1) == 2'd0);
   assign mvalid_e = (req_data.cal_month >= MONTH_FIRST) && (req_data.cal_month <= MONTH_LAST);
   assign midx_e = req_data.cal_month - 4'd1;

   always_ff @(posedge clock) begin
      if (ctl.en[0]) begin
         s1_op_ff   <= req_data.opcode;
         s1_secs_ff <= secs;
         s1_days_ff <= day_prod[DAY_SHIFT +: DAYS_W];
         s1_ok_ff   <= mvalid_e && (req_data.cal_year >= 12'(EPOCH_YEAR));
         s1_yoff_ff <= yoff_e;
         s1_mlen_ff <= mvalid_e ? month_days(midx_e, leap_e) : 5'd0;
         s1_lut_ff  <= days_before(midx_e, leap_e);
         s1_day_ff  <= req_data.cal_day;
         s1_tod_ff  <= 17'(req_data.cal_hour) * SEC_PER_HOUR
                     + 17'(req_data.cal_minute) * SEC_PER_MIN
                     + 17'(req_data.cal_second);
      end
   end

   // stage 2: day product back, quarter-year numerator, encode day count
   op_type            s2_op_ff;
   logic [30:0]       s2_secs_ff;
   logic [DAYS_W-1:0] s2_days_ff;
   logic [30:0]       s2_dprod_ff;
   logic [21:0]       s2_ynum_ff;
   logic [31:0]       s2_days_e_ff;
   logic [16:0]       s2_tod_e_ff;
   logic              s2_ok_ff;
   logic [4:0]        s2_mlen_ff;

   always_ff @(posedge clock) begin
      if (ctl.en[1]) begin
         s2_op_ff     <= s1_op_ff;
         s2_secs_ff   <= s1_secs_ff;
         s2_days_ff   <= s1_days_ff;
         s2_dprod_ff  <= 31'(32'(s1_days_ff) * SEC_PER_DAY);
         s2_ynum_ff   <= 22'(s1_days_ff) * QYEAR_X100 + QYEAR_ROUND;
         s2_days_e_ff <= 32'(s1_day_ff) - 32'd1 + 32'(s1_lut_ff)
                       + 32'(s1_yoff_ff) * DAYS_PER_YEAR + 32'(s1_yoff_ff >> 2);
         s2_tod_e_ff  <= s1_tod_ff;
         s2_ok_ff     <= s1_ok_ff;
         s2_mlen_ff   <= s1_mlen_ff;
      end
   end

   // stage 3: time of day, year offset, encode day seconds
   logic [43:0]       yprod;
   logic [30:0]       tod_diff;

   op_type            s3_op_ff;
   logic [DAYS_W-1:0] s3_days_ff;
   logic [16:0]       s3_tod_ff;
   logic [YOFF_W-1:0] s3_yoff_ff;
   logic [31:0]       s3_eprod_ff;
   logic [16:0]       s3_tod_e_ff;
   logic              s3_ok_ff;
   logic [4:0]        s3_mlen_ff;

   assign yprod = 44'(s2_ynum_ff) * 44'(RECIP_QYEAR);
   assign tod_diff = s2_secs_ff - s2_dprod_ff;

   always_ff @(posedge clock) begin
      if (ctl.en[2]) begin
         s3_op_ff    <= s2_op_ff;
         s3_days_ff  <= s2_days_ff;
         s3_tod_ff   <= tod_diff[16:0];
         s3_yoff_ff  <= yprod[QYEAR_SHIFT +: YOFF_W];
         s3_eprod_ff <= s2_days_e_ff * SEC_PER_DAY;
         s3_tod_e_ff <= s2_tod_e_ff;
         s3_ok_ff    <= s2_ok_ff;
         s3_mlen_ff  <= s2_mlen_ff;
      end
   end

   // stage 4: hour, day of year, encode tick sum
   logic [34:0]       hprod;
   logic [DAYS_W-1:0] ybase;
   logic [DAYS_W-1:0] doy_full;
   logic [31:0]       cnt_e;

   op_type            s4_op_ff;
   logic [16:0]       s4_tod_ff;
   logic [4:0]        s4_hour_ff;
   logic [8:0]        s4_doy_ff;
   logic [YOFF_W-1:0] s4_yoff_ff;
   logic [31:0]       s4_ticks_ff;
   logic              s4_ok_ff;
   logic [4:0]        s4_mlen_ff;

   assign hprod = 35'(s3_tod_ff) * 35'(RECIP_HOUR);
   assign ybase = DAYS_W'(s3_yoff_ff) * DAYS_W'(DAYS_PER_YEAR) + DAYS_W'(s3_yoff_ff >> 2);
   assign doy_full = s3_days_ff - ybase;
   assign cnt_e = 32'(s3_tod_e_ff) + s3_eprod_ff;

   always_ff @(posedge clock) begin
      if (ctl.en[3]) begin
         s4_op_ff    <= s3_op_ff;
         s4_tod_ff   <= s3_tod_ff;
         s4_hour_ff  <= hprod[HOUR_SHIFT +: 5];
         s4_doy_ff   <= doy_full[8:0];
         s4_yoff_ff  <= s3_yoff_ff;
         s4_ticks_ff <= s3_ok_ff ? {cnt_e[30:0], 1'b0} : 32'd0;
         s4_ok_ff    <= s3_ok_ff;
         s4_mlen_ff  <= s3_mlen_ff;
      end
   end

   // stage 5: month search, minute-second remainder
   logic        leap_d;
   logic [3:0]  midx_d;
   logic [16:0] rem_full;
   logic [8:0]  mday_d;

   op_type      s5_op_ff;
   logic [4:0]  s5_hour_ff;
   logic [11:0] s5_year_ff;
   logic [11:0] s5_rem_ff;
   logic [3:0]  s5_month_ff;
   logic [4:0]  s5_day_ff;
   logic [4:0]  s5_mlen_ff;
   logic        s5_ok_ff;
   logic [31:0] s5_ticks_ff;

   assign leap_d = (2'(s4_yoff_ff + YOFF_W'(1)) == 2'd0);

   always_comb begin
      midx_d = 4'd0;
      for (int k = 1; k < 12; k++) begin
         if (days_before(4'(k), leap_d) <= s4_doy_ff) begin
            midx_d = 4'(k);
         end
      end
   end

   assign mday_d = s4_doy_ff - days_before(midx_d, leap_d) + 9'd1;
   assign rem_full = s4_tod_ff - 17'(s4_hour_ff) * SEC_PER_HOUR;

   always_ff @(posedge clock) begin
      if (ctl.en[4]) begin
         s5_op_ff    <= s4_op_ff;
         s5_hour_ff  <= s4_hour_ff;
         s5_year_ff  <= 12'(s4_yoff_ff) + 12'(EPOCH_YEAR);
         s5_rem_ff   <= rem_full[11:0];
         s5_month_ff <= midx_d + 4'd1;
         s5_day_ff   <= mday_d[4:0];
         s5_mlen_ff  <= (s4_op_ff == OP_ENCODE) ? s4_mlen_ff : month_days(midx_d, leap_d);
         s5_ok_ff    <= (s4_op_ff == OP_ENCODE) ? s4_ok_ff : 1'b1;
         s5_ticks_ff <= s4_ticks_ff;
      end
   end

   // stage 6: minute
   logic [24:0] mprod;

   op_type      s6_op_ff;
   logic [4:0]  s6_hour_ff;
   logic [11:0] s6_year_ff;
   logic [11:0] s6_rem_ff;
   logic [5:0]  s6_minute_ff;
   logic [3:0]  s6_month_ff;
   logic [4:0]  s6_day_ff;
   logic [4:0]  s6_mlen_ff;
   logic        s6_ok_ff;
   logic [31:0] s6_ticks_ff;

   assign mprod = 25'(s5_rem_ff) * 25'(RECIP_MIN);

   always_ff @(posedge clock) begin
      if (ctl.en[5]) begin
         s6_op_ff     <= s5_op_ff;
         s6_hour_ff   <= s5_hour_ff;
         s6_year_ff   <= s5_year_ff;
         s6_rem_ff    <= s5_rem_ff;
         s6_minute_ff <= mprod[MIN_SHIFT +: 6];
         s6_month_ff  <= s5_month_ff;
         s6_day_ff    <= s5_day_ff;
         s6_mlen_ff   <= s5_mlen_ff;
         s6_ok_ff     <= s5_ok_ff;
         s6_ticks_ff  <= s5_ticks_ff;
      end
   end

   // stage 7: second and output beat
   logic [11:0] sec_full;
   rsp_type     rsp_in;
   rsp_type     rsp_ff;

   assign sec_full = s6_rem_ff - 12'(s6_minute_ff) * 12'(SEC_PER_MIN);

   always_comb begin
      rsp_in = '0;
      rsp_in.month_length = s6_mlen_ff;
      rsp_in.date_ok = s6_ok_ff;
      unique case (s6_op_ff)
         OP_DECODE: begin
            rsp_in.out_year   = s6_year_ff;
            rsp_in.out_month  = s6_month_ff;
            rsp_in.out_day    = s6_day_ff;
            rsp_in.out_hour   = s6_hour_ff;
            rsp_in.out_minute = s6_minute_ff;
            rsp_in.out_second = sec_full[5:0];
         end
         OP_ENCODE: begin
            rsp_in.out_ticks = s6_ticks_ff;
         end
         default: begin
            rsp_in = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (ctl.en[6]) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_data = rsp_ff;

`ifndef SYNTH
   a_decode_ok: assert property (@(posedge clock) disable iff (reset)
      (ctl.en[6] && ctl.vld[5] && (s6_op_ff == OP_DECODE)) |=> rsp_data.date_ok)
      else $error("decode beat without date_ok");
   a_bad_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_data.date_ok) |-> (rsp_data.out_ticks == 32'd0))
      else $error("invalid date with nonzero ticks");
   a_even_ticks: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !rsp_data.out_ticks[0])
      else $error("odd tick count");
   a_time_range: assert property (@(posedge clock) disable iff (reset)
      (ctl.vld[5] && (s6_op_ff == OP_DECODE)) |->
         ((s6_hour_ff < 5'd24) && (s6_minute_ff < 6'd60) && (sec_full < 12'd60)))
      else $error("decoded time out of range");
`endif

endmodule

// ----- tb/testbench.sv -----
// self-checking testbench for rtc_tick_calendar_converter: directed and random
// tick decodes and calendar encodes, checked against an in-bench conversion model
// depends on rtcc_pkg and the rtl of rtc_tick_calendar_converter
`timescale 1ns / 1ps

module testbench;
   import rtcc_pkg::*;

   localparam int WATCHDOG_LIMIT = 2000;
   localparam int DRAIN_CYCLES = 20;
   localparam int RANDOM_BEATS = 1180;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;

   rsp_type     pending_conversions[$];
   logic        sender_idles = 1'b1;
   logic        receiver_idles = 1'b1;
   int unsigned fail_count = 0;
   int unsigned result_count = 0;
   int unsigned decode_count = 0;
   int unsigned encode_count = 0;
   int unsigned rejected_count = 0;
   int unsigned quiet_cycles = 0;

   rtc_tick_calendar_converter u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   always #5 clock = ~clock;

   // days in month index 0..11
   function automatic logic [4:0] month_span(input int unsigned midx, input logic leap);
      case (midx)
         1: return leap ? 5'd29 : 5'd28;
         3, 5, 8, 10: return 5'd30;
         default: return 5'd31;
      endcase
   endfunction

   function automatic int unsigned days_ahead_of_month(input int unsigned midx,
                                                       input logic leap);
      int unsigned sum;
      sum = 0;
      for (int unsigned i = 0; i < midx; i++) begin
         sum += 32'(month_span(i, leap));
      end
      return sum;
   endfunction

   function automatic rsp_type calendar_convert(input req_type item);
      rsp_type     r;
      logic [31:0] secs, tod, days, yoff, doy, cnt;
      int unsigned m;
      logic        leap;
      r = '0;
      if (item.opcode == OP_DECODE) begin
         secs = item.tick_count >> 1;
         tod = secs % SEC_PER_DAY;
         days = secs / SEC_PER_DAY;
         r.out_hour = 5'(tod / 32'd3600);
         r.out_minute = 6'((tod % 32'd3600) / 32'd60);
         r.out_second = 6'(tod % 32'd60);
         yoff = (days * 32'd100 + 32'd99) / 32'd36525;
         doy = days - (yoff * 32'd36525) / 32'd100;
         leap = ((yoff + 32'd1) & 32'd3) == 32'd0;
         m = 11;
         while (m > 0 && days_ahead_of_month(m, leap) > doy) m--;
         r.out_day = 5'(doy - days_ahead_of_month(m, leap) + 32'd1);
         r.out_month = 4'(m + 1);
         r.out_year = 12'(yoff + EPOCH_YEAR);
         r.month_length = month_span(m, leap);
         r.date_ok = 1'b1;
      end else begin
         yoff = {20'd0, item.cal_year} - EPOCH_YEAR;
         leap = ((yoff + 32'd1) & 32'd3) == 32'd0;
         if (item.cal_month >= MONTH_FIRST && item.cal_month <= MONTH_LAST) begin
            m = 32'(item.cal_month) - 32'd1;
            r.month_length = month_span(m, leap);
            if (32'(item.cal_year) >= EPOCH_YEAR) begin
               days = {27'd0, item.cal_day} - 32'd1 + days_ahead_of_month(m, leap);
               days = days + (yoff * 32'd36525) / 32'd100;
               cnt = {27'd0, item.cal_hour} * 32'd3600 + {26'd0, item.cal_minute} * 32'd60
                     + {26'd0, item.cal_second};
               cnt = cnt + days * SEC_PER_DAY;
               r.out_ticks = cnt << 1;
               r.date_ok = 1'b1;
            end
         end
      end
      return r;
   endfunction

   function automatic logic [31:0] ticks_of(input req_type item);
      rsp_type r;
      r = calendar_convert(item);
      return r.out_ticks;
   endfunction

   function automatic req_type encode_item(input int unsigned y, m, d, h, mi, s);
      req_type     item;
      logic [95:0] noise;
      noise = {$urandom, $urandom, $urandom};
      item = noise[$bits(req_type)-1:0];
      item.opcode = OP_ENCODE;
      item.cal_year = 12'(y);
      item.cal_month = 4'(m);
      item.cal_day = 5'(d);
      item.cal_hour = 5'(h);
      item.cal_minute = 6'(mi);
      item.cal_second = 6'(s);
      return item;
   endfunction

   function automatic req_type decode_item(input logic [31:0] ticks);
      req_type     item;
      logic [95:0] noise;
      noise = {$urandom, $urandom, $urandom};
      item = noise[$bits(req_type)-1:0];
      item.opcode = OP_DECODE;
      item.tick_count = ticks;
      return item;
   endfunction

   function automatic req_type well_formed_encode(input logic wide_years);
      int unsigned y, m;
      y = wide_years ? $urandom_range(EPOCH_YEAR, 4095) : $urandom_range(EPOCH_YEAR, 2076);
      m = $urandom_range(1, 12);
      return encode_item(y, m,
                         $urandom_range(1, month_span(m - 1, ((y - EPOCH_YEAR + 1) % 4) == 0)),
                         $urandom_range(0, 23), $urandom_range(0, 59), $urandom_range(0, 59));
   endfunction

   function automatic req_type random_request();
      int unsigned pick;
      pick = $urandom_range(0, 99);
      if (pick < 40) return decode_item($urandom);
      if (pick < 50) return decode_item(ticks_of(well_formed_encode(1'b0)));
      if (pick < 85) return well_formed_encode($urandom_range(0, 9) == 0);
      return encode_item($urandom_range(0, 4095), $urandom_range(0, 15), $urandom_range(0, 31),
                         $urandom_range(0, 31), $urandom_range(0, 63), $urandom_range(0, 63));
   endfunction

   task automatic note_failure(input string msg);
      fail_count++;
      if (fail_count <= 10) $display("mismatch: %s", msg);
   endtask

   task automatic check_field(input string name, input logic [31:0] want,
                              input logic [31:0] got);
      if (want !== got) begin
         note_failure($sformatf("result %0d %s expected %0d got %0d", result_count, name,
                                want, got));
      end
   endtask

   task automatic send_request(input req_type item);
      int unsigned gap;
      logic        taken;
      rsp_type     want;
      gap = sender_idles ? $urandom_range(0, 9) : 0;
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= item;
      taken = 1'b0;
      while (!taken) begin
         @(negedge clock);
         taken = !req_stall;
         @(posedge clock);
      end
      want = calendar_convert(item);
      pending_conversions.push_back(want);
      if (item.opcode == OP_DECODE) begin
         decode_count++;
      end else begin
         encode_count++;
         if (!want.date_ok) rejected_count++;
      end
   endtask

   task automatic wait_for_results();
      req_valid <= 1'b0;
      while (pending_conversions.size() != 0) @(posedge clock);
   endtask

   task automatic test_directed_decode();
      send_request(decode_item(32'd0));
      send_request(decode_item(32'd1));
      send_request(decode_item(32'hFFFF_FFFF));
      send_request(decode_item(32'hFFFF_FFFE));
      send_request(decode_item(32'd172799));
      send_request(decode_item(32'd172800));
      send_request(decode_item(ticks_of(encode_item(2012, 2, 29, 12, 0, 0))));
      send_request(decode_item(ticks_of(encode_item(2012, 12, 31, 23, 59, 59))));
      send_request(decode_item(ticks_of(encode_item(2013, 1, 1, 0, 0, 0))));
      send_request(decode_item(ticks_of(encode_item(2009, 12, 31, 23, 59, 59))));
   endtask

   task automatic test_directed_encode();
      send_request(encode_item(2009, 1, 1, 0, 0, 0));
      send_request(encode_item(2008, 2, 1, 0, 0, 0));
      send_request(encode_item(0, 13, 5, 1, 1, 1));
      send_request(encode_item(2010, 0, 1, 0, 0, 0));
      send_request(encode_item(2010, 15, 31, 31, 63, 63));
      send_request(encode_item(4095, 12, 31, 31, 63, 63));
      send_request(encode_item(2010, 3, 0, 0, 0, 0));
      send_request(encode_item(2012, 2, 29, 23, 59, 59));
      send_request(encode_item(2013, 2, 28, 0, 0, 0));
      send_request(encode_item(2009, 2, 1, 0, 0, 0));
      send_request(encode_item(2020, 6, 15, 24, 60, 60));
      send_request(encode_item(2077, 1, 1, 0, 0, 0));
   endtask

   task automatic test_random_traffic();
      for (int i = 0; i < RANDOM_BEATS; i++) begin
         if (i % 100 == 0) begin
            sender_idles = $urandom_range(0, 3) != 0;
            receiver_idles = $urandom_range(0, 3) != 0;
         end
         send_request(random_request());
      end
   endtask

   task automatic test_back_to_back();
      sender_idles = 1'b0;
      receiver_idles = 1'b0;
      repeat (150) send_request(random_request());
      receiver_idles = 1'b1;
      repeat (50) send_request(random_request());
      sender_idles = 1'b1;
   endtask

   task automatic test_drain_pause();
      repeat (30) send_request(random_request());
      wait_for_results();
      repeat (30) send_request(random_request());
   endtask

   // result side: random stall per beat while receiver_idles is set, check against oldest expectation
   initial begin
      logic        got;
      int unsigned hold;
      rsp_type     seen;
      rsp_type     want;
      wait (!reset);
      forever begin
         hold = receiver_idles ? $urandom_range(0, 9) : 0;
         if (hold != 0) begin
            rsp_stall <= 1'b1;
            repeat (hold) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         got = 1'b0;
         while (!got) begin
            @(negedge clock);
            got = rsp_valid;
            seen = rsp_data;
            @(posedge clock);
         end
         result_count++;
         if (pending_conversions.size() == 0) begin
            note_failure($sformatf("result %0d arrived with nothing expected", result_count));
         end else begin
            want = pending_conversions.pop_front();
            check_field("out_year", 32'(want.out_year), 32'(seen.out_year));
            check_field("out_month", 32'(want.out_month), 32'(seen.out_month));
            check_field("out_day", 32'(want.out_day), 32'(seen.out_day));
            check_field("out_hour", 32'(want.out_hour), 32'(seen.out_hour));
            check_field("out_minute", 32'(want.out_minute), 32'(seen.out_minute));
            check_field("out_second", 32'(want.out_second), 32'(seen.out_second));
            check_field("out_ticks", want.out_ticks, seen.out_ticks);
            check_field("month_length", 32'(want.month_length), 32'(seen.month_length));
            check_field("date_ok", 32'(want.date_ok), 32'(seen.date_ok));
         end
      end
   end

   always @(negedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no beat accepted for %0d cycles", WATCHDOG_LIMIT);
            $display("Verification failed");
            $finish;
         end
      end
   end

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      test_directed_decode();
      test_directed_encode();
      test_random_traffic();
      test_back_to_back();
      test_drain_pause();
      wait_for_results();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (pending_conversions.size() != 0) begin
         note_failure($sformatf("%0d results never arrived", pending_conversions.size()));
      end
      $display("covered %0d tick decodes and %0d calendar encodes (%0d rejected as invalid)",
               decode_count, encode_count, rejected_count);
      $display("%0d results checked, %0d failures", result_count, fail_count);
      if (fail_count == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
